// ----- design/tgr_pkg.sv -----
// Shared types, widths and wrap helpers for the toroidal grid recenter unit.
`timescale 1ns / 1ps
`default_nettype none

package tgr_pkg;

    localparam int COORD_W = 16;
    localparam int SLOT_W  = 6;
    localparam int IDX_W   = 3;

    typedef struct packed {
        logic                      mode;
        logic signed [COORD_W-1:0] new_center_x;
        logic signed [COORD_W-1:0] new_center_z;
    } t_cmd;

    typedef struct packed {
        logic [SLOT_W-1:0]         slot_index;
        logic signed [COORD_W-1:0] tile_x;
        logic signed [COORD_W-1:0] tile_z;
        logic                      last;
    } t_result;

    // Cursor control from the sequencer to the slot cursor.
    typedef struct packed {
        logic             load;
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] row;
        logic             step_col;
        logic             step_row;
    } t_cur_ctl;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] v,
                                                  input int unsigned gs);
        logic [IDX_W-1:0] r;
        if (32'(v) == gs - 1) begin
            r = '0;
        end else begin
            r = v + IDX_W'(1);
        end
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] v,
                                                  input int unsigned gs);
        logic [IDX_W-1:0] r;
        if (v == '0) begin
            r = IDX_W'(gs - 1);
        end else begin
            r = v - IDX_W'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/tgr_slot_cursor.sv -----
// Storage cursor: wrapping column/row counters and the slot address they select.
`timescale 1ns / 1ps
`default_nettype none

module tgr_slot_cursor #(
    parameter int GRID_SIZE = 8
) (
    input  wire logic                     i_clk,
    input  wire tgr_pkg::t_cur_ctl        i_ctl,
    output logic [tgr_pkg::SLOT_W-1:0]    o_slot,
    output logic                          o_col_end
);
    import tgr_pkg::*;

    logic [IDX_W-1:0] r_col;
    logic [IDX_W-1:0] r_row;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_col <= i_ctl.col;
            r_row <= i_ctl.row;
        end else begin
            if (i_ctl.step_col) begin
                r_col <= wrap_inc(r_col, GRID_SIZE);
            end
            if (i_ctl.step_row) begin
                r_row <= wrap_inc(r_row, GRID_SIZE);
            end
        end
    end

    // row * GRID_SIZE + col, constant multiplier on a 3-bit value
    assign o_slot    = SLOT_W'(r_row) * SLOT_W'(GRID_SIZE) + SLOT_W'(r_col);
    assign o_col_end = (32'(r_col) == GRID_SIZE - 1);

endmodule

`default_nettype wire

// ----- design/toroidal_grid_recenter_unit.sv -----
// Top level: scrolling tile grid recenter sequencer with registered result port.
// Accept moves the sequencer to its run state; each run cycle loads the result register, one result per cycle.
// Shift item: GRID_SIZE results, busy while they are produced; a new command is accepted once busy is low.
// Init item: GRID_SIZE*GRID_SIZE results, busy while they are produced.
// A shift to the current center emits nothing and leaves busy low.
// Synchronous active-low reset clears center, origin, sequencer and strobe.
`timescale 1ns / 1ps
`default_nettype none

module toroidal_grid_recenter_unit #(
    parameter int GRID_SIZE = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    input  wire tgr_pkg::t_cmd    i_cmd,
    output logic                  busy,
    output logic                  o_valid,
    output tgr_pkg::t_result      o_result
);
    import tgr_pkg::*;

    localparam int CNT_W = $clog2(GRID_SIZE * GRID_SIZE);
    localparam logic signed [COORD_W-1:0] HALF = COORD_W'(GRID_SIZE / 2);
    localparam logic signed [COORD_W-1:0] ONE  = COORD_W'(1);

    typedef enum logic {S_IDLE, S_RUN} t_state;
    typedef enum logic [1:0] {K_INIT, K_COL, K_ROW} t_kind;

    t_state                    r_state;
    t_kind                     r_kind;
    logic [CNT_W-1:0]          r_left;
    logic signed [COORD_W-1:0] r_center_col;
    logic signed [COORD_W-1:0] r_center_row;
    logic [IDX_W-1:0]          r_origin_col;
    logic [IDX_W-1:0]          r_origin_row;
    logic signed [COORD_W-1:0] r_tx;
    logic signed [COORD_W-1:0] r_tz;
    logic signed [COORD_W-1:0] r_tx_base;

    t_cur_ctl          cur_ctl;
    logic [SLOT_W-1:0] cur_slot;
    logic              cur_col_end;
    logic              accept;
    logic              dx;
    logic              dz;
    logic [IDX_W-1:0]  org_col_dec;
    logic [IDX_W-1:0]  org_row_dec;

    assign accept      = start && (r_state == S_IDLE);
    assign busy        = (r_state == S_RUN);
    assign dx          = (i_cmd.new_center_x != r_center_col);
    assign dz          = (i_cmd.new_center_z != r_center_row);
    assign org_col_dec = wrap_dec(r_origin_col, GRID_SIZE);
    assign org_row_dec = wrap_dec(r_origin_row, GRID_SIZE);

    always_comb begin
        cur_ctl = '0;
        if (accept) begin
            cur_ctl.load = 1'b1;
            if (i_cmd.mode) begin
                cur_ctl.col = '0;
                cur_ctl.row = '0;
            end else if (dx) begin
                cur_ctl.col = (i_cmd.new_center_x > r_center_col) ? r_origin_col
                                                                 : org_col_dec;
                cur_ctl.row = r_origin_row;
            end else begin
                cur_ctl.col = r_origin_col;
                cur_ctl.row = (i_cmd.new_center_z > r_center_row) ? r_origin_row
                                                                 : org_row_dec;
            end
        end else if (r_state == S_RUN) begin
            unique case (r_kind)
                K_INIT: begin
                    cur_ctl.step_col = 1'b1;
                    cur_ctl.step_row = cur_col_end;
                end
                K_COL:   cur_ctl.step_row = 1'b1;
                K_ROW:   cur_ctl.step_col = 1'b1;
                default: cur_ctl.step_col = 1'b0;
            endcase
        end
    end

    tgr_slot_cursor #(
        .GRID_SIZE (GRID_SIZE)
    ) u_cursor (
        .i_clk     (i_clk),
        .i_ctl     (cur_ctl),
        .o_slot    (cur_slot),
        .o_col_end (cur_col_end)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_kind       <= K_INIT;
            r_left       <= '0;
            r_center_col <= '0;
            r_center_row <= '0;
            r_origin_col <= '0;
            r_origin_row <= '0;
            o_valid      <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_cmd.mode) begin
                            r_center_col <= i_cmd.new_center_x;
                            r_center_row <= i_cmd.new_center_z;
                            r_origin_col <= '0;
                            r_origin_row <= '0;
                            r_tx         <= i_cmd.new_center_x - HALF;
                            r_tx_base    <= i_cmd.new_center_x - HALF;
                            r_tz         <= i_cmd.new_center_z - HALF;
                            r_kind       <= K_INIT;
                            r_left       <= CNT_W'(GRID_SIZE * GRID_SIZE - 1);
                            r_state      <= S_RUN;
                        end else if (dx) begin
                            r_tz   <= r_center_row - HALF;
                            r_kind <= K_COL;
                            r_left <= CNT_W'(GRID_SIZE - 1);
                            r_state <= S_RUN;
                            if (i_cmd.new_center_x > r_center_col) begin
                                r_center_col <= r_center_col + ONE;
                                r_tx         <= r_center_col + HALF;
                                r_origin_col <= wrap_inc(r_origin_col, GRID_SIZE);
                            end else begin
                                r_center_col <= r_center_col - ONE;
                                r_tx         <= r_center_col - (HALF + ONE);
                                r_origin_col <= org_col_dec;
                            end
                        end else if (dz) begin
                            r_tx   <= r_center_col - HALF;
                            r_kind <= K_ROW;
                            r_left <= CNT_W'(GRID_SIZE - 1);
                            r_state <= S_RUN;
                            if (i_cmd.new_center_z > r_center_row) begin
                                r_center_row <= r_center_row + ONE;
                                r_tz         <= r_center_row + HALF;
                                r_origin_row <= wrap_inc(r_origin_row, GRID_SIZE);
                            end else begin
                                r_center_row <= r_center_row - ONE;
                                r_tz         <= r_center_row - (HALF + ONE);
                                r_origin_row <= org_row_dec;
                            end
                        end
                    end
                end
                S_RUN: begin
                    o_valid             <= 1'b1;
                    o_result.slot_index <= cur_slot;
                    o_result.tile_x     <= r_tx;
                    o_result.tile_z     <= r_tz;
                    o_result.last       <= (r_left == '0);
                    r_left              <= r_left - CNT_W'(1);
                    if (r_left == '0) begin
                        r_state <= S_IDLE;
                    end
                    unique case (r_kind)
                        K_INIT: begin
                            // end of a storage row: restart column coordinate
                            if (cur_col_end) begin
                                r_tx <= r_tx_base;
                                r_tz <= r_tz + ONE;
                            end else begin
                                r_tx <= r_tx + ONE;
                            end
                        end
                        K_COL:   r_tz <= r_tz + ONE;
                        K_ROW:   r_tx <= r_tx + ONE;
                        default: r_tx <= r_tx;
                    endcase
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- design/tgr_checker.sv -----
// Port-level checker for the recenter unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module tgr_checker (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic             o_valid,
    input wire tgr_pkg::t_result o_result
);

    // a run emits on every busy cycle
    a_busy_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_valid)
        else $error("busy cycle produced no result");

    // the edge that accepts a command never emits a result
    a_accept_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_valid)
        else $error("result right after accept");

    // mid-run result keeps the unit busy
    a_not_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.last) |-> busy)
        else $error("run ended without last");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.last) |=> !o_valid)
        else $error("result transfer after last");

endmodule

bind toroidal_grid_recenter_unit tgr_checker u_tgr_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the toroidal grid recenter unit: directed and random commands.
`timescale 1ns / 1ps

module tb_top;
    import tgr_pkg::*;

    localparam int GRID_SIZE   = 8;
    localparam int HALF        = GRID_SIZE / 2;
    localparam int STALL_LIMIT = 4000;
    localparam int N_PHASE     = 134;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 16'sh8000;
    localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sh7FFF;

    typedef struct {
        logic drain;
        int   gap_pct;
        t_cmd cmd;
    } t_pending;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_cmd    i_cmd   = '0;
    logic    busy;
    logic    o_valid;
    t_result o_result;

    t_pending cmd_q[$];
    t_result  tile_q[$];

    // predictor state, advanced on every accepted command
    logic signed [COORD_W-1:0] ctr_col = '0;
    logic signed [COORD_W-1:0] ctr_row = '0;
    int unsigned               org_col = 0;
    int unsigned               org_row = 0;

    // center as seen by the stimulus generator, ahead of the block
    logic signed [COORD_W-1:0] gen_col = '0;
    logic signed [COORD_W-1:0] gen_row = '0;

    logic took        = 1'b0;
    int   n_err       = 0;
    int   idle_cycles = 0;
    int   gap_pct     = 17;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    toroidal_grid_recenter_unit #(
        .GRID_SIZE(GRID_SIZE)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_cmd   (i_cmd),
        .busy    (busy),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    task automatic report(input string what, input int got, input int want);
        if (n_err < 200) begin
            $display("ERROR %0t: %s got %0h want %0h", $realtime, what, got, want);
        end
        n_err++;
    endtask

    task automatic push_tile(input int unsigned slot, input int tx, input int tz,
                             input logic fin);
        t_result r;
        r.slot_index = SLOT_W'(slot);
        r.tile_x     = COORD_W'(tx);
        r.tile_z     = COORD_W'(tz);
        r.last       = fin;
        tile_q.push_back(r);
    endtask

    task automatic predict_tiles(input t_cmd c);
        int unsigned line;
        int          coord;
        if (c.mode) begin
            ctr_col = c.new_center_x;
            ctr_row = c.new_center_z;
            org_col = 0;
            org_row = 0;
            for (int z = 0; z < GRID_SIZE; z++) begin
                for (int x = 0; x < GRID_SIZE; x++) begin
                    push_tile(z * GRID_SIZE + x, ctr_col + x - HALF, ctr_row + z - HALF,
                              (z == GRID_SIZE - 1) && (x == GRID_SIZE - 1));
                end
            end
        end else if (c.new_center_x != ctr_col) begin
            if (c.new_center_x > ctr_col) begin
                ctr_col = ctr_col + 1;
                line    = org_col;
                coord   = ctr_col + HALF - 1;
                org_col = (org_col + 1) % GRID_SIZE;
            end else begin
                ctr_col = ctr_col - 1;
                line    = (org_col + GRID_SIZE - 1) % GRID_SIZE;
                coord   = ctr_col - HALF;
                org_col = line;
            end
            // leaving column, rows walked from the wrap origin
            for (int i = 0; i < GRID_SIZE; i++) begin
                push_tile(((org_row + i) % GRID_SIZE) * GRID_SIZE + line, coord,
                          ctr_row + i - HALF, i == GRID_SIZE - 1);
            end
        end else if (c.new_center_z != ctr_row) begin
            if (c.new_center_z > ctr_row) begin
                ctr_row = ctr_row + 1;
                line    = org_row;
                coord   = ctr_row + HALF - 1;
                org_row = (org_row + 1) % GRID_SIZE;
            end else begin
                ctr_row = ctr_row - 1;
                line    = (org_row + GRID_SIZE - 1) % GRID_SIZE;
                coord   = ctr_row - HALF;
                org_row = line;
            end
            for (int i = 0; i < GRID_SIZE; i++) begin
                push_tile(line * GRID_SIZE + (org_col + i) % GRID_SIZE,
                          ctr_col + i - HALF, coord, i == GRID_SIZE - 1);
            end
        end
    endtask

    // queues a command; returns 1 when it will produce tiles
    function automatic bit queue_cmd(input logic mode, input logic signed [COORD_W-1:0] x,
                                     input logic signed [COORD_W-1:0] z);
        t_pending p;
        bit       moves;
        p.drain            = 1'b0;
        p.gap_pct          = gap_pct;
        p.cmd.mode         = mode;
        p.cmd.new_center_x = x;
        p.cmd.new_center_z = z;
        cmd_q.push_back(p);
        moves = mode || (x != gen_col) || (z != gen_row);
        if (mode) begin
            gen_col = x;
            gen_row = z;
        end else if (x != gen_col) begin
            gen_col = (x > gen_col) ? gen_col + 1 : gen_col - 1;
        end else if (z != gen_row) begin
            gen_row = (z > gen_row) ? gen_row + 1 : gen_row - 1;
        end
        return moves;
    endfunction

    function automatic void queue_drain();
        t_pending p;
        p.drain   = 1'b1;
        p.gap_pct = 0;
        p.cmd     = '0;
        cmd_q.push_back(p);
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_coord();
        logic signed [COORD_W-1:0] v;
        case ($urandom_range(0, 19))
            0:       v = COORD_MIN;
            1:       v = COORD_MAX;
            2:       v = '0;
            3:       v = -16'sd1;
            default: v = COORD_W'($urandom_range(0, 65535));
        endcase
        return v;
    endfunction

    function automatic logic signed [COORD_W-1:0] near(input logic signed [COORD_W-1:0] c);
        return COORD_W'(c + int'($urandom_range(0, 8)) - 4);
    endfunction

    // driver: presents the next command once the previous one is transferred
    always @(negedge i_clk) begin
        if (i_rst_n && (!start || took)) begin
            if (cmd_q.size() == 0) begin
                start <= 1'b0;
            end else if (cmd_q[0].drain) begin
                start <= 1'b0;
                if (tile_q.size() == 0) begin
                    void'(cmd_q.pop_front());
                end
            end else if ($urandom_range(0, 99) < cmd_q[0].gap_pct) begin
                start <= 1'b0;
            end else begin
                start <= 1'b1;
                i_cmd <= cmd_q[0].cmd;
                void'(cmd_q.pop_front());
            end
        end
    end

    // monitor: checks tiles against the predicted queue, then predicts new transfers
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            took = start && !busy;
            if (o_valid) begin
                if (tile_q.size() == 0) begin
                    report("unexpected tile, slot_index", o_result.slot_index, 0);
                end else begin
                    want = tile_q.pop_front();
                    if (o_result.slot_index !== want.slot_index)
                        report("slot_index", o_result.slot_index, want.slot_index);
                    if (o_result.tile_x !== want.tile_x)
                        report("tile_x", o_result.tile_x, want.tile_x);
                    if (o_result.tile_z !== want.tile_z)
                        report("tile_z", o_result.tile_z, want.tile_z);
                    if (o_result.last !== want.last)
                        report("last", o_result.last, want.last);
                end
            end
            if (took) begin
                predict_tiles(i_cmd);
            end
            if (took || o_valid) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
    end

    initial begin
        int produced;
        int roll;
        // directed: no-op shift, all four directions, X before Z, extremes, origin wrap
        void'(queue_cmd(1'b0, 16'sd0, 16'sd0));
        void'(queue_cmd(1'b0, 16'sd1, -16'sd1));
        void'(queue_cmd(1'b0, -16'sd2, 16'sd0));
        void'(queue_cmd(1'b0, 16'sd0, 16'sd3));
        void'(queue_cmd(1'b0, 16'sd0, -16'sd3));
        void'(queue_cmd(1'b1, COORD_MAX, COORD_MIN));
        void'(queue_cmd(1'b0, COORD_MIN, COORD_MAX));
        void'(queue_cmd(1'b0, COORD_MAX, COORD_MAX));
        void'(queue_cmd(1'b0, COORD_MAX, COORD_MAX));
        void'(queue_cmd(1'b0, COORD_MAX, COORD_MIN));
        void'(queue_cmd(1'b1, COORD_MIN, COORD_MAX));
        void'(queue_cmd(1'b1, 16'sd0, 16'sd0));
        void'(queue_cmd(1'b0, 16'sd0, -16'sd1));
        for (int i = 0; i < 9; i++) begin
            void'(queue_cmd(1'b0, 16'sd100, -16'sd100));
        end
        queue_drain();

        // random: mostly steps near the current center, some far jumps and re-inits
        for (int ph = 0; ph < 3; ph++) begin
            gap_pct  = (ph == 0) ? 17 : (ph == 1) ? 78 : 0;
            produced = 0;
            while (produced < N_PHASE) begin
                roll = $urandom_range(0, 99);
                if (roll < 4) begin
                    produced += queue_cmd(1'b1, pick_coord(), pick_coord());
                end else if (roll < 80) begin
                    produced += queue_cmd(1'b0, near(gen_col), near(gen_row));
                end else begin
                    produced += queue_cmd(1'b0, pick_coord(), pick_coord());
                end
                if ($urandom_range(0, 49) == 0) begin
                    queue_drain();
                end
            end
            queue_drain();
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        while (!(cmd_q.size() == 0 && !start && tile_q.size() == 0)
               && idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
        end else begin
            repeat (GRID_SIZE * GRID_SIZE + 16) @(posedge i_clk);
            if (n_err == 0 && tile_q.size() == 0) begin
                $display("SCOREBOARD CLEAN");
            end else begin
                $display("SCOREBOARD MISMATCH");
            end
        end
        $finish;
    end

endmodule
